/* src/mpq_pkg.sv */
// ----------------------------------------------------------------------------
// mpq_pkg: shared definitions of the multilevel priority ready queue
// operation kinds, status codes, field widths and level table controls
// ----------------------------------------------------------------------------
`default_nettype none

package mpq_pkg;

	// defaults of the top level parameters
	localparam int NUM_SLOTS_DEF  = 64;
	localparam int NUM_LEVELS_DEF = 10;

	// widths of the stream fields
	localparam int KIND_FW   = 2;
	localparam int SLOT_FW   = 6;
	localparam int PRIO_FW   = 4;
	localparam int STATUS_FW = 2;
	localparam int TDATA_W   = 16;
	localparam int PAD_W     = TDATA_W - SLOT_FW - PRIO_FW;

	typedef enum logic [KIND_FW-1:0] {
		KIND_ENQ = 2'd0,
		KIND_DEQ = 2'd1,
		KIND_SET = 2'd2,
		KIND_GET = 2'd3
	} kind_t;

	typedef enum logic [STATUS_FW-1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_QUEUED   = 2'd2,
		ST_BAD_PRIO = 2'd3
	} status_t;

	// write strobes into the head/tail table
	typedef struct packed {
		logic head_we;
		logic tail_we;
	} lvl_wr_t;

endpackage

`default_nettype wire

/* src/multilevel_priority_ready_queue.sv */
// a dequeue with all queues empty goes from S_PREP straight to S_DONE; get, other dequeues,
// rejected items and a set of an unqueued slot decide in S_INFO; enqueue adds S_APPEND, and
// S_LINK if its level was busy; a set that moves a queued slot first walks its old list
// entry by entry in S_WALK; one item at a time, the next transfer the cycle after
// the result is loaded into the output register, which may still be waiting
// the walk of the old level's link list through the link ram sets the set time
// after reset the slot table is cleared with s_tready low
// ----------------------------------------------------------------------------
// multilevel_priority_ready_queue: fifo ready queues on NUM_LEVELS levels
// the lists run through a link ram, per-slot level and queued flag sit in a
// second ram, head and tail pointers per level sit in registers
// ----------------------------------------------------------------------------
`default_nettype none

module multilevel_priority_ready_queue #(
	parameter int NUM_SLOTS  = mpq_pkg::NUM_SLOTS_DEF,
	parameter int NUM_LEVELS = mpq_pkg::NUM_LEVELS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [mpq_pkg::TDATA_W-1:0]    s_tdata,  // entry_slot, new_priority, pad
	input  wire logic [mpq_pkg::KIND_FW-1:0]    s_tuser,  // kind
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic      [mpq_pkg::TDATA_W-1:0]    m_tdata,  // chosen_slot, entry_priority, pad
	output logic      [mpq_pkg::STATUS_FW-1:0]  m_tuser   // status
);

	import mpq_pkg::*;

	localparam int SW     = $clog2(NUM_SLOTS);
	localparam int LW     = $clog2(NUM_LEVELS);
	localparam int LINK_W = SW + 1;
	localparam int INFO_W = LW + 1;
	localparam logic [LINK_W-1:0] LINK_NULL = {1'b1, {SW{1'b0}}};
	// slot numbers at or above this are folded back into the table
	localparam logic [SLOT_FW:0] SLOTS_CMP =
		(SLOT_FW+1)'((NUM_SLOTS > (1 << SLOT_FW)) ? (1 << SLOT_FW) : NUM_SLOTS);
	localparam logic [PRIO_FW:0] LEVELS_CMP = (PRIO_FW+1)'(NUM_LEVELS);

	typedef enum logic [2:0] {
		S_CLEAR,   // sweep the slot table after reset
		S_IDLE,    // wait for an input transfer
		S_PREP,    // fold the slot number, issue the slot table read
		S_INFO,    // slot table data back, decide
		S_WALK,    // follow the old level's list to the slot
		S_APPEND,  // terminate the slot's link, fill an empty level
		S_LINK,    // hook the slot behind the old tail
		S_DONE     // hand the result to the output register
	} state_t;

	// control and working registers
	state_t            state_q;
	logic [SW-1:0]     clr_cnt_q;
	kind_t             kind_q;
	logic [SLOT_FW-1:0] slot_q;
	logic [PRIO_FW-1:0] prio_q;
	logic [LW-1:0]     lvl_q;
	logic [LINK_W-1:0] cur_q;
	logic [LINK_W-1:0] prev_q;
	logic [SLOT_FW-1:0] res_slot_q;
	logic [PRIO_FW-1:0] res_lvl_q;
	status_t           res_status_q;
	logic              m_tvalid_q;
	logic [TDATA_W-1:0] m_tdata_q;
	status_t           m_tuser_q;

	// slot table ram: queued flag on top, level below
	logic              info_we;
	logic [SW-1:0]     info_waddr;
	logic [INFO_W-1:0] info_wdata;
	logic [SW-1:0]     info_raddr;
	logic [INFO_W-1:0] info_rdata;
	logic [LW-1:0]     info_lvl;
	logic              info_queued;

	// link ram
	logic              link_we;
	logic [SW-1:0]     link_waddr;
	logic [LINK_W-1:0] link_wdata;
	logic [SW-1:0]     link_raddr;
	logic [LINK_W-1:0] link_rdata;

	// head/tail table
	logic [LW-1:0]     lvl_sel;
	lvl_wr_t           lvl_wr;
	logic [LINK_W-1:0] head_d;
	logic [LINK_W-1:0] tail_d;
	logic [LINK_W-1:0] head_sel;
	logic [LINK_W-1:0] tail_sel;
	logic [LW-1:0]     lvl_found;
	logic              lvl_any;

	logic [SW-1:0]     idx;
	logic [LINK_W-1:0] slot_link;
	logic              prio_bad;
	logic              walk_hit;
	logic              out_load;

	assign idx         = SW'(slot_q);
	assign slot_link   = {1'b0, idx};
	assign prio_bad    = {1'b0, prio_q} >= LEVELS_CMP;
	assign info_lvl    = info_rdata[LW-1:0];
	assign info_queued = info_rdata[LW];
	assign walk_hit    = (cur_q == slot_link);
	// result ready and output register free or emptied by this transfer
	assign out_load    = (state_q == S_DONE) && (!m_tvalid_q || m_tready);

	mpq_ram #(
		.WIDTH (INFO_W),
		.DEPTH (NUM_SLOTS)
	) u_info_ram (
		.clk   (clk),
		.we    (info_we),
		.waddr (info_waddr),
		.wdata (info_wdata),
		.raddr (info_raddr),
		.rdata (info_rdata)
	);

	mpq_ram #(
		.WIDTH (LINK_W),
		.DEPTH (NUM_SLOTS)
	) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.raddr (link_raddr),
		.rdata (link_rdata)
	);

	mpq_levels #(
		.NUM_SLOTS  (NUM_SLOTS),
		.NUM_LEVELS (NUM_LEVELS)
	) u_levels (
		.clk      (clk),
		.arst_n   (arst_n),
		.sel      (lvl_sel),
		.wr       (lvl_wr),
		.head_d   (head_d),
		.tail_d   (tail_d),
		.head_sel (head_sel),
		.tail_sel (tail_sel),
		.found    (lvl_found),
		.any      (lvl_any)
	);

	// memory and level table accesses of each step
	always_comb begin
		info_we    = 1'b0;
		info_waddr = idx;
		info_wdata = '0;
		info_raddr = idx;
		link_we    = 1'b0;
		link_waddr = idx;
		link_wdata = LINK_NULL;
		link_raddr = idx;
		lvl_sel    = lvl_q;
		lvl_wr     = '0;
		head_d     = slot_link;
		tail_d     = slot_link;
		unique case (state_q)
			S_CLEAR: begin
				info_we    = 1'b1;
				info_waddr = clr_cnt_q;
			end
			S_PREP: begin
				// dequeue reads the entry at the head of the first busy level
				if (kind_q == KIND_DEQ) begin
					lvl_sel    = lvl_found;
					info_raddr = head_sel[SW-1:0];
					link_raddr = head_sel[SW-1:0];
				end
			end
			S_INFO: begin
				unique case (kind_q)
					KIND_ENQ: begin
						if (!prio_bad && !info_queued) begin
							info_we    = 1'b1;
							info_wdata = {1'b1, LW'(prio_q)};
						end
					end
					KIND_DEQ: begin
						// pop the head, the level empties when its successor is null
						info_we       = 1'b1;
						info_waddr    = cur_q[SW-1:0];
						info_wdata    = {1'b0, info_lvl};
						link_we       = 1'b1;
						link_waddr    = cur_q[SW-1:0];
						lvl_wr.head_we = 1'b1;
						head_d        = link_rdata;
						lvl_wr.tail_we = link_rdata[SW];
						tail_d        = LINK_NULL;
					end
					KIND_SET: begin
						if (!prio_bad) begin
							if (info_queued) begin
								// start the walk at the old level's head
								lvl_sel    = info_lvl;
								link_raddr = head_sel[SW-1:0];
							end else begin
								info_we    = 1'b1;
								info_wdata = {1'b0, LW'(prio_q)};
							end
						end
					end
					KIND_GET: begin
					end
				endcase
			end
			S_WALK: begin
				link_raddr = link_rdata[SW-1:0];
				if (walk_hit) begin
					// bridge around the slot
					if (!prev_q[SW]) begin
						link_we    = 1'b1;
						link_waddr = prev_q[SW-1:0];
						link_wdata = link_rdata;
					end else begin
						lvl_wr.head_we = 1'b1;
						head_d         = link_rdata;
					end
					if (tail_sel == cur_q) begin
						lvl_wr.tail_we = 1'b1;
						tail_d         = prev_q;
					end
					info_we    = 1'b1;
					info_wdata = {1'b1, LW'(prio_q)};
				end else if (cur_q[SW]) begin
					info_we    = 1'b1;
					info_wdata = {1'b1, LW'(prio_q)};
				end
			end
			S_APPEND: begin
				link_we = 1'b1;
				if (tail_sel[SW]) begin
					lvl_wr.head_we = 1'b1;
					lvl_wr.tail_we = 1'b1;
				end
			end
			S_LINK: begin
				link_we        = 1'b1;
				link_waddr     = tail_sel[SW-1:0];
				link_wdata     = slot_link;
				lvl_wr.tail_we = 1'b1;
			end
			S_IDLE, S_DONE: begin
			end
		endcase
	end

	// sequencer, working registers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_cnt_q    <= '0;
			kind_q       <= KIND_ENQ;
			slot_q       <= '0;
			prio_q       <= '0;
			lvl_q        <= '0;
			cur_q        <= LINK_NULL;
			prev_q       <= LINK_NULL;
			res_slot_q   <= '0;
			res_lvl_q    <= '0;
			res_status_q <= ST_OK;
			m_tvalid_q   <= 1'b0;
			m_tdata_q    <= '0;
			m_tuser_q    <= ST_OK;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
				m_tdata_q  <= {{PAD_W{1'b0}}, res_lvl_q, res_slot_q};
				m_tuser_q  <= res_status_q;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == SW'(NUM_SLOTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						kind_q  <= kind_t'(s_tuser);
						slot_q  <= s_tdata[SLOT_FW-1:0];
						prio_q  <= s_tdata[SLOT_FW +: PRIO_FW];
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					if (kind_q != KIND_DEQ && {1'b0, slot_q} >= SLOTS_CMP) begin
						slot_q <= slot_q - SLOTS_CMP[SLOT_FW-1:0];
					end else if (kind_q == KIND_DEQ && !lvl_any) begin
						res_slot_q   <= '0;
						res_lvl_q    <= '0;
						res_status_q <= ST_EMPTY;
						state_q      <= S_DONE;
					end else begin
						lvl_q   <= lvl_found;
						cur_q   <= head_sel;
						state_q <= S_INFO;
					end
				end
				S_INFO: begin
					res_slot_q <= (kind_q == KIND_DEQ) ? SLOT_FW'(cur_q[SW-1:0]) : slot_q;
					unique case (kind_q)
						KIND_ENQ: begin
							if (prio_bad) begin
								res_lvl_q    <= PRIO_FW'(info_lvl);
								res_status_q <= ST_BAD_PRIO;
								state_q      <= S_DONE;
							end else if (info_queued) begin
								res_lvl_q    <= PRIO_FW'(info_lvl);
								res_status_q <= ST_QUEUED;
								state_q      <= S_DONE;
							end else begin
								res_lvl_q    <= prio_q;
								res_status_q <= ST_OK;
								lvl_q        <= LW'(prio_q);
								state_q      <= S_APPEND;
							end
						end
						KIND_DEQ: begin
							res_lvl_q    <= PRIO_FW'(info_lvl);
							res_status_q <= ST_OK;
							state_q      <= S_DONE;
						end
						KIND_SET: begin
							if (prio_bad) begin
								res_lvl_q    <= PRIO_FW'(info_lvl);
								res_status_q <= ST_BAD_PRIO;
								state_q      <= S_DONE;
							end else if (info_queued) begin
								res_lvl_q    <= prio_q;
								res_status_q <= ST_OK;
								lvl_q        <= info_lvl;
								prev_q       <= LINK_NULL;
								cur_q        <= head_sel;
								state_q      <= S_WALK;
							end else begin
								res_lvl_q    <= prio_q;
								res_status_q <= ST_OK;
								state_q      <= S_DONE;
							end
						end
						KIND_GET: begin
							res_lvl_q    <= PRIO_FW'(info_lvl);
							res_status_q <= ST_OK;
							state_q      <= S_DONE;
						end
					endcase
				end
				S_WALK: begin
					if (walk_hit || cur_q[SW]) begin
						lvl_q   <= LW'(prio_q);
						state_q <= S_APPEND;
					end else begin
						prev_q <= cur_q;
						cur_q  <= link_rdata;
					end
				end
				S_APPEND: begin
					if (tail_sel[SW]) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_LINK;
					end
				end
				S_LINK: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

`default_nettype wire

/* src/mpq_ram.sv */
// ----------------------------------------------------------------------------
// mpq_ram: generic single-port-write, single-port-read synchronous ram
// one write and one registered read per cycle, read data from the address of the previous cycle
// ----------------------------------------------------------------------------
`default_nettype none

module mpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

/* src/mpq_levels.sv */
// ----------------------------------------------------------------------------
// mpq_levels: head and tail pointers of every priority level
// one selected level is read and written per cycle; finds the first busy level
// ----------------------------------------------------------------------------
`default_nettype none

module mpq_levels #(
	parameter int NUM_SLOTS  = mpq_pkg::NUM_SLOTS_DEF,
	parameter int NUM_LEVELS = mpq_pkg::NUM_LEVELS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic [$clog2(NUM_LEVELS)-1:0]   sel,
	input  wire mpq_pkg::lvl_wr_t                wr,
	input  wire logic [$clog2(NUM_SLOTS):0]      head_d,
	input  wire logic [$clog2(NUM_SLOTS):0]      tail_d,
	output logic      [$clog2(NUM_SLOTS):0]      head_sel,
	output logic      [$clog2(NUM_SLOTS):0]      tail_sel,
	output logic      [$clog2(NUM_LEVELS)-1:0]   found,
	output logic                                 any
);

	import mpq_pkg::*;

	localparam int SW     = $clog2(NUM_SLOTS);
	localparam int LW     = $clog2(NUM_LEVELS);
	localparam int LINK_W = SW + 1;
	localparam logic [LINK_W-1:0] LINK_NULL = {1'b1, {SW{1'b0}}};

	logic [LINK_W-1:0]     head_q [NUM_LEVELS];
	logic [LINK_W-1:0]     tail_q [NUM_LEVELS];
	logic [NUM_LEVELS-1:0] busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LEVELS; i++) begin
				head_q[i] <= LINK_NULL;
				tail_q[i] <= LINK_NULL;
			end
		end else begin
			if (wr.head_we) begin
				head_q[sel] <= head_d;
			end
			if (wr.tail_we) begin
				tail_q[sel] <= tail_d;
			end
		end
	end

	assign head_sel = head_q[sel];
	assign tail_sel = tail_q[sel];

	// lowest-numbered non-empty level wins
	always_comb begin
		found = '0;
		for (int i = 0; i < NUM_LEVELS; i++) begin
			busy[i] = !head_q[i][SW];
		end
		for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
			if (busy[i]) begin
				found = LW'(i);
			end
		end
	end

	assign any = |busy;

endmodule

`default_nettype wire

/* src/mpq_checker.sv */
// ----------------------------------------------------------------------------
// mpq_checker: port-level checks of the multilevel priority ready queue
// bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module mpq_checker #(
	parameter int NUM_LEVELS = mpq_pkg::NUM_LEVELS_DEF
) (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          s_tvalid,
	input wire logic                          s_tready,
	input wire logic                          m_tvalid,
	input wire logic                          m_tready,
	input wire logic [mpq_pkg::TDATA_W-1:0]   m_tdata,
	input wire logic [mpq_pkg::STATUS_FW-1:0] m_tuser
);

	import mpq_pkg::*;

	localparam logic [PRIO_FW:0] LEVELS_CMP = (PRIO_FW+1)'(NUM_LEVELS);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// one item at a time: no transfer in the cycle after one
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in work");

	// an empty dequeue reports slot and level as zero
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_EMPTY) |-> (m_tdata == '0))
		else $error("empty result carries data");

	// a reported level is always a real level
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ({1'b0, m_tdata[SLOT_FW +: PRIO_FW]} < LEVELS_CMP))
		else $error("level beyond the last one");

	// the padding of a result is zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[TDATA_W-1:SLOT_FW+PRIO_FW] == '0))
		else $error("result padding not zero");

endmodule

bind multilevel_priority_ready_queue mpq_checker #(
	.NUM_LEVELS (NUM_LEVELS)
) u_mpq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire
